// File: src/three_round_dispense_sequencer_assert.svh
// Assertion macros used by the dispense sequencer checker
`ifndef THREE_ROUND_DISPENSE_SEQUENCER_ASSERT_SVH
`define THREE_ROUND_DISPENSE_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked while out of reset
`define TRDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dispense sequencer check failed");

// Next-cycle implication, checked while out of reset
`define TRDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dispense sequencer check failed");

`endif

// File: src/trds_pkg.sv
// Types, codes and helpers for the three-round dispense sequencer
package trds_pkg;

    localparam int TRDS_ROUNDS = 3;

    localparam logic [14:0] SIDE_OFFSET_RESET = 15'd100;
    localparam logic [15:0] DETECT_WINDOW_RESET = 16'd5000;

    localparam logic signed [17:0] TGT_MAX = 18'sd32767;
    localparam logic signed [17:0] TGT_MIN = -18'sd32768;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_ABORT = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        RES_NONE    = 2'd0,
        RES_SUCCESS = 2'd1,
        RES_EMPTY   = 2'd2
    } res_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_MOVE   = 3'd1,
        PH_PUSH   = 3'd2,
        PH_RETURN = 3'd3,
        PH_WINDOW = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic {
        CFG_SIDE_OFFSET   = 1'b0,
        CFG_DETECT_WINDOW = 1'b1
    } cfg_idx_t;

    // Center plus round offset (-a, 0, +a), saturated to 16 bits
    function automatic logic signed [15:0] trds_target(
        input logic signed [15:0] center,
        input logic [1:0]         rnd,
        input logic [14:0]        a
    );
        logic signed [17:0] off;
        logic signed [17:0] sum;
        logic signed [15:0] res;
        begin
            off = '0;
            if (rnd == 2'd0)
            begin
                off = -$signed({3'b000, a});
            end
            else if (rnd == 2'd2)
            begin
                off = $signed({3'b000, a});
            end
            sum = $signed({{2{center[15]}}, center}) + off;
            if (sum > TGT_MAX)
            begin
                res = 16'sh7fff;
            end
            else if (sum < TGT_MIN)
            begin
                res = 16'sh8000;
            end
            else
            begin
                res = sum[15:0];
            end
            return res;
        end
    endfunction

endpackage

// File: src/three_round_dispense_sequencer.sv
// Three-round dispense sequencer: request stage, sequencer logic and result register
//
// Usage: requests (tick, start, abort) arrive on the in_valid/in_ready channel with
// the sensor and time fields of that cycle; every request yields exactly one result
// on the out_valid/out_ready channel carrying the command pulses and status levels.
// Configuration (side offset, detection window) is written through cfg_we,
// cfg_index and cfg_data while no request is in flight; writes take effect at once.
// A request accepted into the request register passes through the sequencer logic
// into the result register once that register is empty or being read. Throughput is one
// request per cycle while the receiver does not stall; the sequencer state is read and
// updated between request register and result register.
// When the receiver stalls, the result register holds and the request register
// still takes one more request; in_ready drops only when both are full.
// Reset clears the sequencer to idle with result none, the offset to 100 steps and
// the window to 5000 ms; both channels are empty after reset.
module three_round_dispense_sequencer
    import trds_pkg::*;
#(
    parameter int ROUNDS = TRDS_ROUNDS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [15:0] slot_center,
    input  logic               slot_ok,
    input  logic               axis_busy,
    input  logic               servo_busy,
    input  logic               ir_detected,
    input  logic [31:0]        now_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               move_start,
    output logic signed [15:0] move_target,
    output logic               push_start,
    output logic               servo_return,
    output logic               axis_stop,
    output logic               ir_enable,
    output logic               ir_clear,
    output logic               busy_res,
    output logic               complete,
    output logic [1:0]         outcome
);

    localparam logic [1:0] LAST_ROUND = 2'(ROUNDS - 1);

    logic [14:0]        side_offset_reg;
    logic [15:0]        window_ms_reg;

    logic               s_valid_reg;
    logic [1:0]         s_req_reg;
    logic signed [15:0] s_center_reg;
    logic               s_slot_ok_reg;
    logic               s_axis_busy_reg;
    logic               s_servo_busy_reg;
    logic               s_ir_reg;
    logic [31:0]        s_now_reg;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [1:0]         round_reg;
    logic [1:0]         round_next;
    logic signed [15:0] center_reg;
    logic signed [15:0] center_next;
    res_t               result_reg;
    res_t               result_next;
    logic [31:0]        wstart_reg;
    logic [31:0]        wstart_next;

    logic               out_valid_reg;
    logic               move_start_reg;
    logic               move_start_next;
    logic signed [15:0] move_target_reg;
    logic signed [15:0] move_target_next;
    logic               push_start_reg;
    logic               push_start_next;
    logic               servo_return_reg;
    logic               servo_return_next;
    logic               axis_stop_reg;
    logic               axis_stop_next;
    logic               ir_clear_reg;
    logic               ir_clear_next;
    logic               busy_reg;
    logic               busy_next;
    logic               complete_reg;
    logic               complete_next;

    logic               adv;
    logic               in_prog;
    logic [31:0]        elapsed;
    logic               expired;

    assign adv      = s_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s_valid_reg || adv;
    assign in_prog  = (phase_reg != PH_IDLE) && (phase_reg != PH_DONE);
    assign elapsed  = s_now_reg - wstart_reg;
    assign expired  = elapsed >= {16'd0, window_ms_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_offset_reg <= SIDE_OFFSET_RESET;
            window_ms_reg   <= DETECT_WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SIDE_OFFSET:   side_offset_reg <= cfg_data[14:0];
                CFG_DETECT_WINDOW: window_ms_reg   <= cfg_data;
                default:           window_ms_reg   <= window_ms_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s_req_reg        <= req_type;
            s_center_reg     <= slot_center;
            s_slot_ok_reg    <= slot_ok;
            s_axis_busy_reg  <= axis_busy;
            s_servo_busy_reg <= servo_busy;
            s_ir_reg         <= ir_detected;
            s_now_reg        <= now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            round_reg  <= 2'd0;
            center_reg <= '0;
            result_reg <= RES_NONE;
            wstart_reg <= '0;
        end
        else if (adv)
        begin
            phase_reg  <= phase_next;
            round_reg  <= round_next;
            center_reg <= center_next;
            result_reg <= result_next;
            wstart_reg <= wstart_next;
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        round_next        = round_reg;
        center_next       = center_reg;
        result_next       = result_reg;
        wstart_next       = wstart_reg;
        move_start_next   = 1'b0;
        push_start_next   = 1'b0;
        servo_return_next = 1'b0;
        axis_stop_next    = 1'b0;
        ir_clear_next     = 1'b0;

        case (req_t'(s_req_reg))
            REQ_START:
            begin
                if (!in_prog)
                begin
                    if (!s_slot_ok_reg)
                    begin
                        result_next = RES_EMPTY;
                        phase_next  = PH_DONE;
                    end
                    else
                    begin
                        center_next     = s_center_reg;
                        round_next      = 2'd0;
                        result_next     = RES_NONE;
                        wstart_next     = '0;
                        ir_clear_next   = 1'b1;
                        move_start_next = 1'b1;
                        phase_next      = PH_MOVE;
                    end
                end
            end
            REQ_ABORT:
            begin
                servo_return_next = 1'b1;
                axis_stop_next    = 1'b1;
                phase_next        = PH_DONE;
            end
            REQ_TICK:
            begin
                if (in_prog && s_ir_reg)
                begin
                    result_next       = RES_SUCCESS;
                    servo_return_next = 1'b1;
                    axis_stop_next    = 1'b1;
                    phase_next        = PH_DONE;
                end
                else
                begin
                    case (phase_reg)
                        PH_MOVE:
                        begin
                            if (!s_axis_busy_reg)
                            begin
                                push_start_next = 1'b1;
                                phase_next      = PH_PUSH;
                            end
                        end
                        PH_PUSH:
                        begin
                            if (!s_servo_busy_reg)
                            begin
                                servo_return_next = 1'b1;
                                if (round_reg >= LAST_ROUND)
                                begin
                                    wstart_next = s_now_reg;
                                    phase_next  = PH_WINDOW;
                                end
                                else
                                begin
                                    phase_next = PH_RETURN;
                                end
                            end
                        end
                        PH_RETURN:
                        begin
                            if (!s_servo_busy_reg)
                            begin
                                round_next      = round_reg + 2'd1;
                                move_start_next = 1'b1;
                                phase_next      = PH_MOVE;
                            end
                        end
                        PH_WINDOW:
                        begin
                            if (expired)
                            begin
                                result_next       = RES_EMPTY;
                                servo_return_next = 1'b1;
                                axis_stop_next    = 1'b1;
                                phase_next        = PH_DONE;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        move_target_next = move_start_next ?
            trds_target(center_next, round_next, side_offset_reg) : 16'sd0;
        busy_next        = (phase_next != PH_IDLE) && (phase_next != PH_DONE);
        complete_next    = phase_next == PH_DONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            move_start_reg   <= move_start_next;
            move_target_reg  <= move_target_next;
            push_start_reg   <= push_start_next;
            servo_return_reg <= servo_return_next;
            axis_stop_reg    <= axis_stop_next;
            ir_clear_reg     <= ir_clear_next;
            busy_reg         <= busy_next;
            complete_reg     <= complete_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign move_start   = move_start_reg;
    assign move_target  = move_target_reg;
    assign push_start   = push_start_reg;
    assign servo_return = servo_return_reg;
    assign axis_stop    = axis_stop_reg;
    assign ir_enable    = busy_reg;
    assign ir_clear     = ir_clear_reg;
    assign busy_res     = busy_reg;
    assign complete     = complete_reg;
    assign outcome      = result_reg;

endmodule

// File: src/trds_checker.sv
// Port-level checker for the dispense sequencer and its bind
`include "three_round_dispense_sequencer_assert.svh"

module trds_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               move_start,
    input logic signed [15:0] move_target,
    input logic               axis_stop,
    input logic               servo_return,
    input logic               ir_enable,
    input logic               busy_res,
    input logic               complete
);

    logic end_seen;

    assign end_seen = complete && servo_return && !ir_enable;

    `TRDS_ASSERT_NOW(a_ir_follows_busy, clk, rst_n, out_valid, ir_enable == busy_res)
    `TRDS_ASSERT_NOW(a_busy_not_done, clk, rst_n, out_valid, !(busy_res && complete))
    `TRDS_ASSERT_NOW(a_stop_ends_seq, clk, rst_n, out_valid && axis_stop, end_seen)
    `TRDS_ASSERT_NOW(a_move_in_seq, clk, rst_n, out_valid && !move_start, move_target == 16'sd0)
    `TRDS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(move_target))

endmodule

bind three_round_dispense_sequencer trds_checker u_trds_checker (.*);
